// File: rtl/core/pdx_pkg.sv
// Package for the packet deframer with XOR check: phase and status codes,
// result record and fixed frame constants. No dependencies.
`default_nettype none

package pdx_pkg;

    localparam int HEADER_BYTES = 5;
    localparam int FOOTER_BYTES = 4;
    localparam logic [15:0] MAX_MESSAGE_BYTES = 16'd1024;

    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_MARKER = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOKEN_MARKER = 1'd1;

    localparam logic [7:0] START_MARKER_RESET = 8'd27;
    localparam logic [7:0] TOKEN_MARKER_RESET = 8'd14;

    typedef enum logic [2:0] {
        PH_WAIT   = 3'd0,
        PH_SEQ    = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_LEN_LO = 3'd3,
        PH_TOKEN  = 3'd4,
        PH_BODY   = 3'd5,
        PH_FOOTER = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_START = 3'd1,
        ST_BAD_TOKEN = 3'd2,
        ST_BAD_SUM   = 3'd3,
        ST_TOO_LONG  = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0]  echo_byte;
        logic        is_payload;
        logic        frame_done;
        status_t     frame_status;
        logic [7:0]  sequence_number;
        logic [15:0] message_length;
    } res_t;

endpackage

`default_nettype wire

// File: rtl/core/pdx_parser.sv
// Frame parser: marker registers, phase machine, XOR lanes and the result
// of the byte being transferred. Depends on pdx_pkg.
`default_nettype none

module pdx_parser (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire logic [7:0]                   rx_byte,
    input  wire logic                         cfg_we,
    input  wire logic [pdx_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]                   cfg_data,
    output pdx_pkg::res_t                     result
);
    import pdx_pkg::*;

    logic [7:0]  start_marker_reg;
    logic [7:0]  token_marker_reg;
    phase_t      phase_reg,   phase_next;
    logic [15:0] count_reg,   count_next;
    logic [15:0] length_reg,  length_next;
    logic [7:0]  seq_reg,     seq_next;
    logic [31:0] lanes_reg,   lanes_next;
    logic [1:0]  ptr_reg,     ptr_next;
    logic        mismatch_reg, mismatch_next;

    logic        payload;
    logic        done;
    status_t     status;
    logic [15:0] count_inc;
    logic [15:0] len_lo_value;
    logic [7:0]  footer_lane;
    logic [31:0] fold_lanes;
    logic [1:0]  fold_ptr;

    assign count_inc    = count_reg + 16'd1;
    assign len_lo_value = {length_reg[15:8], rx_byte};
    assign footer_lane  = lanes_reg[{count_reg[1:0], 3'b000} +: 8];
    assign fold_lanes   = lanes_reg ^ ({24'd0, rx_byte} << {ptr_reg, 3'b000});
    assign fold_ptr     = ptr_reg + 2'd1;

    // next state and datapath
    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        length_next   = length_reg;
        seq_next      = seq_reg;
        lanes_next    = lanes_reg;
        ptr_next      = ptr_reg;
        mismatch_next = mismatch_reg;
        unique case (phase_reg)
            PH_SEQ:
            begin
                seq_next   = rx_byte;
                lanes_next = fold_lanes;
                ptr_next   = fold_ptr;
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                length_next = {rx_byte, 8'd0};
                lanes_next  = fold_lanes;
                ptr_next    = fold_ptr;
                phase_next  = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                length_next = len_lo_value;
                lanes_next  = fold_lanes;
                ptr_next    = fold_ptr;
                phase_next  = (len_lo_value > MAX_MESSAGE_BYTES) ? PH_WAIT : PH_TOKEN;
            end
            PH_TOKEN:
            begin
                if (rx_byte != token_marker_reg)
                begin
                    phase_next = PH_WAIT;
                end
                else
                begin
                    lanes_next    = fold_lanes;
                    ptr_next      = fold_ptr;
                    count_next    = 16'd0;
                    mismatch_next = 1'b0;
                    phase_next    = (length_reg == 16'd0) ? PH_FOOTER : PH_BODY;
                end
            end
            PH_BODY:
            begin
                lanes_next = fold_lanes;
                ptr_next   = fold_ptr;
                count_next = count_inc;
                if (count_inc >= length_reg)
                begin
                    count_next    = 16'd0;
                    mismatch_next = 1'b0;
                    phase_next    = PH_FOOTER;
                end
            end
            PH_FOOTER:
            begin
                if (footer_lane != rx_byte)
                begin
                    mismatch_next = 1'b1;
                end
                count_next = count_inc;
                if (count_inc >= 16'(FOOTER_BYTES))
                begin
                    count_next = 16'd0;
                    phase_next = PH_WAIT;
                end
            end
            default:
            begin
                // waiting, and the unused code
                seq_next      = 8'd0;
                length_next   = 16'd0;
                count_next    = 16'd0;
                mismatch_next = 1'b0;
                if (rx_byte == start_marker_reg)
                begin
                    lanes_next = {24'd0, rx_byte};
                    ptr_next   = 2'd1;
                    phase_next = PH_SEQ;
                end
                else
                begin
                    lanes_next = 32'd0;
                    ptr_next   = 2'd0;
                    phase_next = PH_WAIT;
                end
            end
        endcase
    end

    // result flags
    always_comb
    begin
        payload = 1'b0;
        done    = 1'b0;
        status  = ST_OK;
        unique case (phase_reg)
            PH_SEQ, PH_LEN_HI:
            begin
            end
            PH_LEN_LO:
            begin
                if (len_lo_value > MAX_MESSAGE_BYTES)
                begin
                    done   = 1'b1;
                    status = ST_TOO_LONG;
                end
            end
            PH_TOKEN:
            begin
                if (rx_byte != token_marker_reg)
                begin
                    done   = 1'b1;
                    status = ST_BAD_TOKEN;
                end
            end
            PH_BODY:
            begin
                payload = 1'b1;
            end
            PH_FOOTER:
            begin
                if (count_inc >= 16'(FOOTER_BYTES))
                begin
                    done   = 1'b1;
                    status = (mismatch_next) ? ST_BAD_SUM : ST_OK;
                end
            end
            default:
            begin
                if (rx_byte != start_marker_reg)
                begin
                    done   = 1'b1;
                    status = ST_BAD_START;
                end
            end
        endcase
    end

    assign result.echo_byte       = rx_byte;
    assign result.is_payload      = payload;
    assign result.frame_done      = done;
    assign result.frame_status    = status;
    assign result.sequence_number = seq_next;
    assign result.message_length  = length_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= START_MARKER_RESET;
            token_marker_reg <= TOKEN_MARKER_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_MARKER: start_marker_reg <= cfg_data;
                CFG_TOKEN_MARKER: token_marker_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_WAIT;
            count_reg    <= 16'd0;
            length_reg   <= 16'd0;
            seq_reg      <= 8'd0;
            lanes_reg    <= 32'd0;
            ptr_reg      <= 2'd0;
            mismatch_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            length_reg   <= length_next;
            seq_reg      <= seq_next;
            lanes_reg    <= lanes_next;
            ptr_reg      <= ptr_next;
            mismatch_reg <= mismatch_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/pdx_out_reg.sv
// Result register between the parser and the output channel, with the
// upstream stall derived from it. Depends on pdx_pkg.
`default_nettype none

module pdx_out_reg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire pdx_pkg::res_t res_in,
    output logic               out_valid,
    input  wire logic          out_stall,
    output pdx_pkg::res_t      res_out
);
    import pdx_pkg::*;

    logic valid_reg;
    res_t res_reg;
    logic load;

    // a held result that is not being taken blocks the next transfer
    assign in_stall = valid_reg && out_stall;
    assign load     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

`default_nettype wire

// File: rtl/core/packet_deframer_xor_check_top.sv
// Top level of the packet deframer with XOR check.
// Depends on pdx_pkg, pdx_parser and pdx_out_reg.
`default_nettype none

// One received byte is taken per clock while not stalled and gives exactly one
// result, registered in the single result register, which holds the last result
// while the output side stalls and then stalls the input in turn. The frame
// parser updates its phase, counters and XOR lanes on each transfer. The user
// must write the marker registers through cfg_we, cfg_index and cfg_data only
// while no frame is in flight; the block itself does not enforce this.
module packet_deframer_xor_check_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [7:0]                      rx_byte,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [7:0]                           echo_byte,
    output logic                                 is_payload,
    output logic                                 frame_done,
    output logic [2:0]                           frame_status,
    output logic [7:0]                           sequence_number,
    output logic [15:0]                          message_length,
    input  wire logic                            cfg_we,
    input  wire logic [pdx_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]                      cfg_data
);
    import pdx_pkg::*;

    res_t res_comb;
    res_t res_held;
    logic accept;

    assign accept = in_valid && !in_stall;

    pdx_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (res_comb)
    );

    pdx_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .res_in    (res_comb),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_out   (res_held)
    );

    assign echo_byte       = res_held.echo_byte;
    assign is_payload      = res_held.is_payload;
    assign frame_done      = res_held.frame_done;
    assign frame_status    = res_held.frame_status;
    assign sequence_number = res_held.sequence_number;
    assign message_length  = res_held.message_length;

endmodule

`default_nettype wire
